// ----- sv/conv2d_forward_output_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the convolution output block
// Shorthand for clocked implications, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef CONV2D_FORWARD_OUTPUT_MACROS_SVH
`define CONV2D_FORWARD_OUTPUT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define C2DFO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define C2DFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/c2dfo_pkg.sv -----
// ---------------------------------------------------------------------------
// Convolution output block package
// Transaction types, register layout, codes and arithmetic widths.
// ---------------------------------------------------------------------------
package c2dfo_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int SUM_W    = 40;
  localparam int ACC_W    = 42;
  localparam int COORD_W  = 6;
  localparam int XW       = 12;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_PIXEL  = 2'd1,
    OP_COMPUTE   = 2'd2
  } c2dfo_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_HEIGHT = 3'd0,
    CFG_KERNEL_WIDTH  = 3'd1,
    CFG_STRIDE_ROWS   = 3'd2,
    CFG_STRIDE_COLS   = 3'd3,
    CFG_PAD_ROWS      = 3'd4,
    CFG_PAD_COLS      = 3'd5,
    CFG_PLANE_HEIGHT  = 3'd6,
    CFG_PLANE_WIDTH   = 3'd7
  } c2dfo_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } c2dfo_state_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]   partial_in;
  } c2dfo_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] partial_out;
    logic                    saturated;
  } c2dfo_out_t;

  typedef struct packed {
    logic [3:0] kernel_height;
    logic [3:0] kernel_width;
    logic [3:0] stride_rows;
    logic [3:0] stride_cols;
    logic [2:0] pad_rows;
    logic [2:0] pad_cols;
    logic [6:0] plane_height;
    logic [6:0] plane_width;
  } c2dfo_cfg_t;

  typedef struct packed {
    logic load;
    logic tap_live;
  } c2dfo_mac_ctrl_t;

  localparam c2dfo_cfg_t CFG_RESET = '{
    kernel_height: 4'd3,
    kernel_width:  4'd3,
    stride_rows:   4'd1,
    stride_cols:   4'd1,
    pad_rows:      3'd1,
    pad_cols:      3'd1,
    plane_height:  7'd32,
    plane_width:   7'd32
  };

endpackage

// ----- sv/c2dfo_seq.sv -----
// ---------------------------------------------------------------------------
// Convolution tap sequencer
// Walks the kernel window one tap per cycle and forms store addresses.
// ---------------------------------------------------------------------------
module c2dfo_seq import c2dfo_pkg::*; #(
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8,
  parameter int MAX_PLANE_ROWS  = 64,
  parameter int MAX_PLANE_COLS  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  c2dfo_cfg_t         cfg_i,
  input  logic               out_free_i,
  output logic               idle_o,
  output logic               done_o,
  output c2dfo_mac_ctrl_t    ctrl_o,
  output logic [((MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1)-1:0] wk_row_o,
  output logic [((MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1)-1:0] wk_col_o,
  output logic [((MAX_PLANE_ROWS > 1) ? $clog2(MAX_PLANE_ROWS) : 1)-1:0]   px_row_o,
  output logic [((MAX_PLANE_COLS > 1) ? $clog2(MAX_PLANE_COLS) : 1)-1:0]   px_col_o
);

  localparam int KRW = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
  localparam int KCW = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
  localparam int PRW = (MAX_PLANE_ROWS > 1) ? $clog2(MAX_PLANE_ROWS) : 1;
  localparam int PCW = (MAX_PLANE_COLS > 1) ? $clog2(MAX_PLANE_COLS) : 1;
  localparam int KHW = $clog2(MAX_KERNEL_ROWS + 1);
  localparam int KWW = $clog2(MAX_KERNEL_COLS + 1);
  localparam int PHW = $clog2(MAX_PLANE_ROWS + 1);
  localparam int PWW = $clog2(MAX_PLANE_COLS + 1);

  c2dfo_state_e   state_q, state_d;
  logic [KRW-1:0] kr_q, kr_d;
  logic [KCW-1:0] kc_q, kc_d;
  logic           drain_q, drain_d;
  logic [XW-1:0]  base_r_q, base_c_q;
  logic [XW-1:0]  base_r_d, base_c_d;
  logic [KHW-1:0] kh_n;
  logic [KWW-1:0] kw_n;
  logic [PHW-1:0] ph_n;
  logic [PWW-1:0] pw_n;
  logic [XW-1:0]  xr, xc;
  logic           row_ok, col_ok, row_last, col_last, no_taps;

  assign kh_n = (int'(cfg_i.kernel_height) > MAX_KERNEL_ROWS) ?
                KHW'(MAX_KERNEL_ROWS) : KHW'(cfg_i.kernel_height);
  assign kw_n = (int'(cfg_i.kernel_width) > MAX_KERNEL_COLS) ?
                KWW'(MAX_KERNEL_COLS) : KWW'(cfg_i.kernel_width);
  assign ph_n = (int'(cfg_i.plane_height) > MAX_PLANE_ROWS) ?
                PHW'(MAX_PLANE_ROWS) : PHW'(cfg_i.plane_height);
  assign pw_n = (int'(cfg_i.plane_width) > MAX_PLANE_COLS) ?
                PWW'(MAX_PLANE_COLS) : PWW'(cfg_i.plane_width);

  assign base_r_d = XW'(cfg_i.stride_rows) * XW'(row_i) - XW'(cfg_i.pad_rows);
  assign base_c_d = XW'(cfg_i.stride_cols) * XW'(col_i) - XW'(cfg_i.pad_cols);

  assign xr = base_r_q + XW'(kr_q);
  assign xc = base_c_q + XW'(kc_q);

  assign row_ok   = !xr[XW-1] && (xr < XW'(ph_n));
  assign col_ok   = !xc[XW-1] && (xc < XW'(pw_n));
  assign row_last = (KHW'(kr_q) + KHW'(1)) == kh_n;
  assign col_last = (KWW'(kc_q) + KWW'(1)) == kw_n;
  assign no_taps  = (kh_n == '0) || (kw_n == '0);

  assign wk_row_o = kr_q;
  assign wk_col_o = kc_q;
  assign px_row_o = xr[PRW-1:0];
  assign px_col_o = xc[PCW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kr_q    <= '0;
      kc_q    <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kr_q    <= kr_d;
      kc_q    <= kc_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      base_r_q <= base_r_d;
      base_c_q <= base_c_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    kr_d            = kr_q;
    kc_d            = kc_q;
    drain_d         = drain_q;
    idle_o          = 1'b0;
    done_o          = 1'b0;
    ctrl_o.load     = 1'b0;
    ctrl_o.tap_live = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o      = 1'b1;
        ctrl_o.load = start_i;
        if (start_i) begin
          kr_d    = '0;
          kc_d    = '0;
          state_d = no_taps ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl_o.tap_live = row_ok && col_ok;
        if (col_last) begin
          kc_d = '0;
          if (row_last) begin
            drain_d = 1'b0;
            state_d = ST_DRAIN;
          end else begin
            kr_d = kr_q + KRW'(1);
          end
        end else begin
          kc_d = kc_q + KCW'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        done_o = out_free_i;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/c2dfo_mac.sv -----
// ---------------------------------------------------------------------------
// Convolution multiply-accumulate unit
// One signed product per tap, summed exactly, then clipped to 40 bits.
// ---------------------------------------------------------------------------
module c2dfo_mac import c2dfo_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  c2dfo_mac_ctrl_t            ctrl_i,
  input  logic signed [SUM_W-1:0]    partial_i,
  input  logic signed [SAMPLE_W-1:0] pix_i,
  input  logic signed [SAMPLE_W-1:0] wgt_i,
  output logic [SUM_W-1:0]           sum_o,
  output logic                       sat_o
);

  logic                     live_q;
  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [ACC_W-SUM_W:0]     top_bits;
  logic                     in_range;

  assign mult   = pix_i * wgt_i;
  assign prod_d = live_q ? mult : '0;

  assign acc_d = ctrl_i.load ?
                 {{(ACC_W - SUM_W){partial_i[SUM_W-1]}}, partial_i} :
                 acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      prod_q <= '0;
    end else begin
      live_q <= ctrl_i.tap_live;
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign top_bits = acc_q[ACC_W-1:SUM_W-1];
  assign in_range = (&top_bits) || !(|top_bits);
  assign sat_o    = !in_range;

  always_comb begin
    if (in_range) begin
      sum_o = acc_q[SUM_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      sum_o = {1'b1, {(SUM_W - 1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(SUM_W - 1){1'b1}}};
    end
  end

endmodule

// ----- sv/conv2d_forward_output.sv -----
// ---------------------------------------------------------------------------
// Strided, zero-padded 2-D convolution output element
// Weight and pixel write transactions keep the block ready.
// A compute transaction holds ready low while the kernel window, clamped to its maximum, is
// walked (an empty kernel is skipped): one tap per cycle through the single multiply-accumulate
// unit, then through the store read, product and accumulate registers. Its result is valid
// in the cycle ready returns; the block waits longer while an earlier result is still held.
// Reset clears control and loads the register defaults; the stores are undefined until written.
// ---------------------------------------------------------------------------
module conv2d_forward_output import c2dfo_pkg::*; #(
  parameter int MAX_KERNEL_ROWS = 8,
  parameter int MAX_KERNEL_COLS = 8,
  parameter int MAX_PLANE_ROWS  = 64,
  parameter int MAX_PLANE_COLS  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  c2dfo_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output c2dfo_out_t           out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int KRW = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
  localparam int KCW = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
  localparam int PRW = (MAX_PLANE_ROWS > 1) ? $clog2(MAX_PLANE_ROWS) : 1;
  localparam int PCW = (MAX_PLANE_COLS > 1) ? $clog2(MAX_PLANE_COLS) : 1;

  c2dfo_cfg_t      cfg_q;
  c2dfo_mac_ctrl_t mac_ctrl;
  logic            accept, start, idle, done, out_free;
  logic            wgt_we, pix_we;
  logic [KRW-1:0]  wk_row;
  logic [KCW-1:0]  wk_col;
  logic [PRW-1:0]  px_row;
  logic [PCW-1:0]  px_col;
  logic [SAMPLE_W-1:0] wgt_mem [MAX_KERNEL_ROWS][MAX_KERNEL_COLS];
  logic [SAMPLE_W-1:0] pix_mem [MAX_PLANE_ROWS][MAX_PLANE_COLS];
  logic [SAMPLE_W-1:0] wgt_rd_q, pix_rd_q;
  logic [SUM_W-1:0]    sum;
  logic                sat;
  logic                out_valid_q;
  c2dfo_out_t          out_data_q;

  assign in_ready_o = idle;
  assign accept     = in_valid_i && idle;
  assign start      = accept && (in_data_i.operation == OP_COMPUTE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    wgt_we = 1'b0;
    pix_we = 1'b0;
    case (in_data_i.operation)
      OP_WR_WEIGHT: wgt_we = accept && (int'(in_data_i.row) < MAX_KERNEL_ROWS) &&
                             (int'(in_data_i.col) < MAX_KERNEL_COLS);
      OP_WR_PIXEL:  pix_we = accept && (int'(in_data_i.row) < MAX_PLANE_ROWS) &&
                             (int'(in_data_i.col) < MAX_PLANE_COLS);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_data_i[3:0];
        CFG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_data_i[3:0];
        CFG_STRIDE_ROWS:   cfg_q.stride_rows   <= cfg_data_i[3:0];
        CFG_STRIDE_COLS:   cfg_q.stride_cols   <= cfg_data_i[3:0];
        CFG_PAD_ROWS:      cfg_q.pad_rows      <= cfg_data_i[2:0];
        CFG_PAD_COLS:      cfg_q.pad_cols      <= cfg_data_i[2:0];
        CFG_PLANE_HEIGHT:  cfg_q.plane_height  <= cfg_data_i;
        CFG_PLANE_WIDTH:   cfg_q.plane_width   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[KRW'(in_data_i.row)][KCW'(in_data_i.col)] <= in_data_i.sample;
    end
    if (mac_ctrl.tap_live) begin
      wgt_rd_q <= wgt_mem[wk_row][wk_col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[PRW'(in_data_i.row)][PCW'(in_data_i.col)] <= in_data_i.sample;
    end
    if (mac_ctrl.tap_live) begin
      pix_rd_q <= pix_mem[px_row][px_col];
    end
  end

  c2dfo_seq #(
    .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS(MAX_KERNEL_COLS),
    .MAX_PLANE_ROWS (MAX_PLANE_ROWS),
    .MAX_PLANE_COLS (MAX_PLANE_COLS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .row_i     (in_data_i.row),
    .col_i     (in_data_i.col),
    .cfg_i     (cfg_q),
    .out_free_i(out_free),
    .idle_o    (idle),
    .done_o    (done),
    .ctrl_o    (mac_ctrl),
    .wk_row_o  (wk_row),
    .wk_col_o  (wk_col),
    .px_row_o  (px_row),
    .px_col_o  (px_col)
  );

  c2dfo_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .partial_i(in_data_i.partial_in),
    .pix_i    (pix_rd_q),
    .wgt_i    (wgt_rd_q),
    .sum_o    (sum),
    .sat_o    (sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q.partial_out <= sum;
      out_data_q.saturated   <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/c2dfo_chk.sv -----
// ---------------------------------------------------------------------------
// Convolution output block port checker
// Watches the top-level ports and checks transaction ordering and results.
// ---------------------------------------------------------------------------
`include "conv2d_forward_output_macros.svh"

module c2dfo_chk import c2dfo_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input c2dfo_in_t  in_data_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input c2dfo_out_t out_data_i
);

  `C2DFO_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "Output transaction changed before it was taken.")
  `C2DFO_ASSERT_NEXT(a_busy_after_compute, in_valid_i && in_ready_i && (in_data_i.operation == OP_COMPUTE), !in_ready_i, "Block still ready after a compute transaction.")
  `C2DFO_ASSERT_NEXT(a_ready_after_write, in_valid_i && in_ready_i && (in_data_i.operation != OP_COMPUTE), in_ready_i, "Block busy after a write transaction.")
  `C2DFO_ASSERT_NOW(a_result_from_busy, $rose(out_valid_i), !$past(in_ready_i), "Result appeared without a compute in progress.")
  `C2DFO_ASSERT_NOW(a_sat_at_limit, out_valid_i && out_data_i.saturated, (out_data_i.partial_out == 40'h7F_FFFF_FFFF) || (out_data_i.partial_out == 40'h80_0000_0000), "Clipped result is not at a range limit.")

endmodule

bind conv2d_forward_output c2dfo_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);
